### rtl/fsk_pkg.sv
`default_nettype none
package fsk_pkg;
    localparam int TAPS_N_DEF = 1024;
    localparam int LO_N_DEF = 1024;
    localparam int FRAME_N_DEF = 16;
    localparam int THR_W = 40;
    localparam logic [THR_W-1:0] THR_RESET = 40'd10000;
    localparam int IDX_W = 10;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_COEF   = 2'd1,
        OP_LO     = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        logic [IDX_W-1:0] idx;
        logic signed [31:0] coef;
    } cmd_t;
endpackage
`default_nettype wire

### rtl/fsk_downconvert_fir_discriminator_unit.sv
// FSK quadrature discriminator.
// s_axis carries one command transaction: sample, coefficient write or
// oscillator table write, selected by tuser. m_axis carries one result per
// frame of FRAME_N samples: data bit, squelch flag, cross product, magnitude squared.
// cfg_we writes the 40-bit squelch threshold; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Front: oscillator lookup and mixer. A sample goes through s1 and s2 to the
// output register, a coefficient write goes straight to it and an oscillator
// write only writes the tables; no command is taken while a sample is in
// flight or the output register is full. Back: history rings and I and Q
// multiply-accumulates over TAPS_N taps sharing one coefficient read, run
// after the last sample of a frame; the back takes no command while it runs.
// After reset the history rings are cleared, one entry per cycle: the back
// takes no command until the clear is done; the front fills its output register
// and the two-entry queue, then holds s_axis_tready low.
// A stalled m_axis holds the result; the back finishes the next frame and
// waits, the queue fills and s_axis_tready drops.
`default_nettype none
module fsk_downconvert_fir_discriminator_unit import fsk_pkg::*; #(
    parameter int TAPS_N = TAPS_N_DEF,
    parameter int LO_N = LO_N_DEF,
    parameter int FRAME_N = FRAME_N_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [39:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // sample[15:0], table_index[25:16], coefficient[57:26], lo_cosine[73:58],
    // lo_sine[89:74], zero fill
    input  wire logic [95:0]  s_axis_tdata,
    // operation[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // data_bit[0], squelched[1], cross_product[65:2], magnitude_squared[129:66], zero fill
    output logic [135:0]      m_axis_tdata
);
    logic [THR_W-1:0] thr_reg;
    logic fq_valid, fq_ready, qb_valid, qb_ready;
    cmd_t fq_cmd, qb_cmd;
    logic [129:0] res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    fsk_front #(.LO_N(LO_N)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_op(s_axis_tuser),
        .in_sample(s_axis_tdata[15:0]), .in_idx(s_axis_tdata[25:16]),
        .in_coef(s_axis_tdata[57:26]), .in_cos(s_axis_tdata[73:58]),
        .in_sin(s_axis_tdata[89:74]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
    );

    fsk_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .w_valid(fq_valid), .w_ready(fq_ready), .w_cmd(fq_cmd),
        .r_valid(qb_valid), .r_ready(qb_ready), .r_cmd(qb_cmd)
    );

    fsk_back #(.TAPS_N(TAPS_N), .FRAME_N(FRAME_N)) u_back (
        .clk(clk), .rst_n(rst_n), .thr(thr_reg),
        .c_valid(qb_valid), .c_ready(qb_ready), .c_cmd(qb_cmd),
        .o_valid(m_axis_tvalid), .o_ready(m_axis_tready), .o_data(res)
    );

    assign m_axis_tdata = {6'd0, res};
endmodule
`default_nettype wire

### rtl/fsk_ram.sv
`default_nettype none
module fsk_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/fsk_front.sv
`default_nettype none
module fsk_front import fsk_pkg::*; #(
    parameter int LO_N = LO_N_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  in_op,
    input  wire logic signed [15:0] in_sample,
    input  wire logic [IDX_W-1:0] in_idx,
    input  wire logic signed [31:0] in_coef,
    input  wire logic signed [15:0] in_cos,
    input  wire logic signed [15:0] in_sin,
    output logic             q_valid,
    input  wire logic        q_ready,
    output cmd_t             q_cmd
);
    localparam int LW = $clog2(LO_N);

    logic [LW-1:0] lo_idx_reg;
    logic          s1_valid_reg;
    logic signed [15:0] s1_sample_reg;
    logic          s2_valid_reg;
    logic          out_valid_reg;
    cmd_t          out_cmd_reg;
    logic [15:0]   cos_rd, sin_rd;
    logic signed [31:0] pi_reg, pq_reg;
    logic          lo_we;
    logic          take;
    logic          busy;

    assign busy = s1_valid_reg || s2_valid_reg || out_valid_reg;
    assign in_ready = !busy;
    assign take = in_valid && in_ready;
    assign lo_we = take && (op_t'(in_op) == OP_LO) && (32'(in_idx) < LO_N);

    fsk_ram #(.WIDTH(16), .DEPTH(LO_N)) u_cos (
        .clk(clk), .we(lo_we), .waddr(in_idx[LW-1:0]), .wdata(in_cos),
        .raddr(lo_idx_reg), .rdata(cos_rd)
    );
    fsk_ram #(.WIDTH(16), .DEPTH(LO_N)) u_sin (
        .clk(clk), .we(lo_we), .waddr(in_idx[LW-1:0]), .wdata(in_sin),
        .raddr(lo_idx_reg), .rdata(sin_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_idx_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s1_valid_reg <= 1'b0;
            if (out_valid_reg && q_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (take)
            begin
                if (op_t'(in_op) == OP_SAMPLE)
                begin
                    s1_valid_reg <= 1'b1;
                end
                else if (op_t'(in_op) == OP_COEF)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            if (s1_valid_reg)
            begin
                lo_idx_reg <= lo_idx_reg + 1'b1;
            end
            if (s2_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_sample_reg <= in_sample;
            out_cmd_reg.op <= op_t'(in_op);
            out_cmd_reg.idx <= in_idx;
            out_cmd_reg.coef <= in_coef;
        end
        if (s1_valid_reg)
        begin
            pi_reg <= s1_sample_reg * $signed(cos_rd);
            pq_reg <= s1_sample_reg * $signed(sin_rd);
        end
        if (s2_valid_reg)
        begin
            out_cmd_reg.i_val <= pi_reg[30:15];
            out_cmd_reg.q_val <= pq_reg[30:15];
        end
    end

    assign q_valid = out_valid_reg;
    assign q_cmd = out_cmd_reg;
endmodule
`default_nettype wire

### rtl/fsk_queue.sv
`default_nettype none
module fsk_queue import fsk_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic w_valid,
    output logic      w_ready,
    input  wire cmd_t w_cmd,
    output logic      r_valid,
    input  wire logic r_ready,
    output cmd_t      r_cmd
);
    cmd_t mem_reg [2];
    logic [1:0] cnt_reg;
    logic wp_reg, rp_reg;
    logic wr, rd;

    assign w_ready = cnt_reg != 2'd2;
    assign r_valid = cnt_reg != 2'd0;
    assign r_cmd = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= w_cmd;
        end
    end
endmodule
`default_nettype wire

### rtl/fsk_back.sv
`default_nettype none
module fsk_back import fsk_pkg::*; #(
    parameter int TAPS_N = TAPS_N_DEF,
    parameter int FRAME_N = FRAME_N_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic [THR_W-1:0] thr,
    input  wire logic c_valid,
    output logic      c_ready,
    input  wire cmd_t c_cmd,
    output logic      o_valid,
    input  wire logic o_ready,
    output logic [129:0] o_data
);
    localparam int TW = $clog2(TAPS_N);
    localparam int FW = $clog2(FRAME_N + 1);

    typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_MAC, S_DRAIN, S_SCALE, S_MUL, S_SUM, S_OUT} st_t;
    st_t st_reg;

    logic [TW-1:0] head_reg, clr_reg, rd_reg, k_reg;
    logic [FW-1:0] pos_reg;
    logic [TW:0]   cnt_reg;
    logic          mac_v_reg, mac_v2_reg;
    logic signed [63:0] acc_i_reg, acc_q_reg;
    logic signed [47:0] pi_reg, pq_reg, ci_reg, cq_reg;
    logic [1:0]    part_reg;
    logic [63:0]   m1_reg, m2_reg, m3_reg, m4_reg;
    logic [63:0]   cross_reg, mag_reg;
    logic [63:0]   pi_x, pq_x, ci_x, cq_x;
    logic signed [47:0] prod_i_reg, prod_q_reg;
    logic [15:0]   hi_rd, hq_rd;
    logic [31:0]   cf_rd;
    logic          h_we, cf_we;
    logic [TW-1:0] h_wa;
    logic [15:0]   h_wi, h_wq;
    logic          take;
    logic          sq;
    logic          bit_v;

    // one 32 x 32 partial product of a 64-bit product, modulo 2**64
    function automatic logic [63:0] part_prod(input logic [63:0] a, input logic [63:0] b,
                                              input logic [1:0] p);
        logic [63:0] full;
        logic [31:0] mid;
        full = '0;
        mid = '0;
        case (p)
            2'd0: full = {32'd0, a[31:0]} * {32'd0, b[31:0]};
            2'd1:
            begin
                mid = a[31:0] * b[63:32];
                full = {mid, 32'd0};
            end
            default:
            begin
                mid = a[63:32] * b[31:0];
                full = {mid, 32'd0};
            end
        endcase
        return full;
    endfunction

    assign c_ready = (st_reg == S_IDLE);
    assign take = c_valid && c_ready;
    assign cf_we = take && c_cmd.op == OP_COEF && (32'(c_cmd.idx) < TAPS_N);
    assign h_we = (st_reg == S_CLEAR) || (take && c_cmd.op == OP_SAMPLE);
    assign h_wa = (st_reg == S_CLEAR) ? clr_reg : head_reg + TW'(pos_reg);
    assign h_wi = (st_reg == S_CLEAR) ? 16'd0 : c_cmd.i_val;
    assign h_wq = (st_reg == S_CLEAR) ? 16'd0 : c_cmd.q_val;

    assign pi_x = {{16{pi_reg[47]}}, pi_reg};
    assign pq_x = {{16{pq_reg[47]}}, pq_reg};
    assign ci_x = {{16{ci_reg[47]}}, ci_reg};
    assign cq_x = {{16{cq_reg[47]}}, cq_reg};

    fsk_ram #(.WIDTH(16), .DEPTH(TAPS_N)) u_hi (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wi), .raddr(rd_reg), .rdata(hi_rd)
    );
    fsk_ram #(.WIDTH(16), .DEPTH(TAPS_N)) u_hq (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wq), .raddr(rd_reg), .rdata(hq_rd)
    );
    fsk_ram #(.WIDTH(32), .DEPTH(TAPS_N)) u_cf (
        .clk(clk), .we(cf_we), .waddr(c_cmd.idx[TW-1:0]), .wdata(c_cmd.coef),
        .raddr(k_reg), .rdata(cf_rd)
    );

    assign sq = $signed(mag_reg) < $signed({24'd0, thr});
    assign bit_v = sq || ($signed(cross_reg) > 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR;
            clr_reg <= '0;
            head_reg <= '0;
            pos_reg <= '0;
            pi_reg <= '0;
            pq_reg <= '0;
            mac_v_reg <= 1'b0;
            mac_v2_reg <= 1'b0;
            o_valid <= 1'b0;
        end
        else
        begin
            mac_v2_reg <= mac_v_reg;
            mac_v_reg <= (st_reg == S_MAC);
            case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == TW'(TAPS_N - 1))
                    begin
                        st_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (take && c_cmd.op == OP_SAMPLE)
                    begin
                        if (pos_reg == FW'(FRAME_N - 1))
                        begin
                            pos_reg <= '0;
                            head_reg <= head_reg + TW'(FRAME_N);
                            rd_reg <= head_reg + TW'(FRAME_N);
                            k_reg <= '0;
                            cnt_reg <= '0;
                            acc_i_reg <= '0;
                            acc_q_reg <= '0;
                            st_reg <= S_MAC;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                S_MAC:
                begin
                    rd_reg <= rd_reg + 1'b1;
                    k_reg <= k_reg + 1'b1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (TW+1)'(TAPS_N - 1))
                    begin
                        st_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!mac_v_reg && !mac_v2_reg)
                    begin
                        st_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    ci_reg <= acc_i_reg[63:16];
                    cq_reg <= acc_q_reg[63:16];
                    m1_reg <= '0;
                    m2_reg <= '0;
                    m3_reg <= '0;
                    m4_reg <= '0;
                    part_reg <= '0;
                    st_reg <= S_MUL;
                end
                S_MUL:
                begin
                    m1_reg <= m1_reg + part_prod(pi_x, cq_x, part_reg);
                    m2_reg <= m2_reg + part_prod(ci_x, pq_x, part_reg);
                    m3_reg <= m3_reg + part_prod(ci_x, ci_x, part_reg);
                    m4_reg <= m4_reg + part_prod(cq_x, cq_x, part_reg);
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd2)
                    begin
                        st_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    cross_reg <= m1_reg - m2_reg;
                    mag_reg <= m3_reg + m4_reg;
                    pi_reg <= ci_reg;
                    pq_reg <= cq_reg;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!o_valid)
                    begin
                        o_valid <= 1'b1;
                        o_data <= {mag_reg, cross_reg, sq, bit_v};
                        st_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
            if (o_valid && o_ready)
            begin
                o_valid <= 1'b0;
            end
            if (mac_v2_reg)
            begin
                acc_i_reg <= acc_i_reg + 64'(prod_i_reg);
                acc_q_reg <= acc_q_reg + 64'(prod_q_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_i_reg <= $signed(hi_rd) * $signed(cf_rd);
        prod_q_reg <= $signed(hq_rd) * $signed(cf_rd);
    end
endmodule
`default_nettype wire
